/* rtl/core/lfpd_pkg.sv */
package lfpd_pkg;

  localparam int unsigned ThreshW = 10;
  localparam int unsigned GainW   = 12;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned PosW    = 11;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ErrW    = 12;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SumW    = 28;

  localparam logic signed [ErrW-1:0] CENTER_POSITION = 12'sd1000;
  localparam logic signed [ErrW-1:0] HALF_POSITION   = 12'sd500;

  localparam logic [SpeedW-1:0] SPEED_STRAIGHT  = 8'd85;
  localparam logic [SpeedW-1:0] SPEED_CORNER    = 8'd90;
  localparam logic [SpeedW-1:0] SPEED_SLANT_OUT = 8'd90;
  localparam logic [SpeedW-1:0] SPEED_SLANT_IN  = 8'd60;

  localparam logic [ThreshW-1:0]  RST_THRESH  = 10'd500;
  localparam logic [GainW-1:0]    RST_KP      = 12'd90;
  localparam logic [GainW-1:0]    RST_KD      = 12'd768;
  localparam logic [SpeedW-1:0]   RST_BASE    = 8'd85;
  localparam logic [SpeedW-1:0]   RST_CEIL    = 8'd200;
  localparam logic [TimeoutW-1:0] RST_TIMEOUT = 16'd350;

  typedef enum logic [2:0] {
    CASE_NORMAL   = 3'd0,
    CASE_DASHED   = 3'd1,
    CASE_SLANT_L  = 3'd2,
    CASE_SLANT_R  = 3'd3,
    CASE_CORNER_L = 3'd4,
    CASE_CORNER_R = 3'd5
  } track_case_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESH_L = 3'd0,
    REG_THRESH_C = 3'd1,
    REG_THRESH_R = 3'd2,
    REG_KP       = 3'd3,
    REG_KD       = 3'd4,
    REG_BASE     = 3'd5,
    REG_CEIL     = 3'd6,
    REG_TIMEOUT  = 3'd7
  } cfg_reg_e;

endpackage

/* rtl/core/line_follower_pd_steering.sv */
// Each accepted input is held in the input register and moves on to the result register.
// Throughput: one item per cycle while out_stall_i is low; the input register and
// the result register let a new item enter while a finished result waits on out_stall_i.
// Reset (rst_ni low, asynchronous): pipeline empty, registers at their defaults,
// last error and last line time cleared to zero.
module line_follower_pd_steering
  import lfpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ThreshW-1:0]  reading_left_i,
  input  logic [ThreshW-1:0]  reading_center_i,
  input  logic [ThreshW-1:0]  reading_right_i,
  input  logic [PosW-1:0]     line_position_i,
  input  logic [TimeW-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SpeedW-1:0]   left_speed_o,
  output logic                left_forward_o,
  output logic [SpeedW-1:0]   right_speed_o,
  output logic                right_forward_o,
  output logic [2:0]          track_case_o
);

  // configuration
  logic [ThreshW-1:0]  thl_q, thc_q, thr_q;
  logic [GainW-1:0]    kp_q, kd_q;
  logic [SpeedW-1:0]   base_q, ceil_q;
  logic [TimeoutW-1:0] timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thl_q     <= RST_THRESH;
      thc_q     <= RST_THRESH;
      thr_q     <= RST_THRESH;
      kp_q      <= RST_KP;
      kd_q      <= RST_KD;
      base_q    <= RST_BASE;
      ceil_q    <= RST_CEIL;
      timeout_q <= RST_TIMEOUT;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_THRESH_L: thl_q     <= cfg_data_i[ThreshW-1:0];
        REG_THRESH_C: thc_q     <= cfg_data_i[ThreshW-1:0];
        REG_THRESH_R: thr_q     <= cfg_data_i[ThreshW-1:0];
        REG_KP:       kp_q      <= cfg_data_i[GainW-1:0];
        REG_KD:       kd_q      <= cfg_data_i[GainW-1:0];
        REG_BASE:     base_q    <= cfg_data_i[SpeedW-1:0];
        REG_CEIL:     ceil_q    <= cfg_data_i[SpeedW-1:0];
        REG_TIMEOUT:  timeout_q <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_full_q;
  logic [ThreshW-1:0] rl_q, rc_q, rr_q;
  logic [PosW-1:0]    pos_q;
  logic [TimeW-1:0]   now_q;
  logic               advance;
  logic               in_accept;

  assign advance    = in_full_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_accept) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rl_q  <= reading_left_i;
      rc_q  <= reading_center_i;
      rr_q  <= reading_right_i;
      pos_q <= line_position_i;
      now_q <= now_ms_i;
    end
  end

  // state
  logic signed [ErrW-1:0] last_err_q, last_err_d;
  logic [TimeW-1:0]       last_time_q;

  // decision logic
  logic                   bl, bc, br, toward_left, dashed;
  logic [TimeW-1:0]       elapsed;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW:0]   diff;
  logic signed [GainW:0]  kp_s, kd_s;
  logic signed [24:0]     p_term;
  logic signed [25:0]     d_term;
  logic signed [17:0]     base_ext;
  logic signed [SumW-1:0] corr, sum_l, sum_r;

  logic [SpeedW-1:0] ls_d, rs_d;
  logic              lf_d, rf_d;
  track_case_e       tc_d;

  function automatic logic [SpeedW-1:0] pd_clamp(logic signed [SumW-1:0] s,
                                                 logic [SpeedW-1:0] ceiling);
    logic [SumW-10:0] whole;
    whole = s[SumW-2:8];
    if (s[SumW-1]) begin
      return '0;
    end else if (whole > (SumW-9)'(ceiling)) begin
      return ceiling;
    end else begin
      return whole[SpeedW-1:0];
    end
  endfunction

  always_comb begin
    bl          = rl_q > thl_q;
    bc          = rc_q > thc_q;
    br          = rr_q > thr_q;
    toward_left = (last_err_q <= 0);
    dashed      = !bl && !bc && !br;
    elapsed     = now_q - last_time_q;

    err      = $signed({1'b0, pos_q}) - CENTER_POSITION;
    diff     = {err[ErrW-1], err} - {last_err_q[ErrW-1], last_err_q};
    kp_s     = $signed({1'b0, kp_q});
    kd_s     = $signed({1'b0, kd_q});
    p_term   = kp_s * err;
    d_term   = kd_s * diff;
    base_ext = $signed({2'b00, base_q, 8'h00});
    corr     = SumW'(p_term) + SumW'(d_term);
    sum_l    = SumW'(base_ext) + corr;
    sum_r    = SumW'(base_ext) - corr;

    last_err_d = last_err_q;
    ls_d = SPEED_CORNER;
    rs_d = SPEED_CORNER;
    lf_d = 1'b1;
    rf_d = 1'b0;
    tc_d = CASE_NORMAL;

    if (dashed) begin
      tc_d = CASE_DASHED;
      if (elapsed < TimeW'(timeout_q)) begin
        ls_d = SPEED_STRAIGHT;
        rs_d = SPEED_STRAIGHT;
        rf_d = 1'b1;
      end else if (!toward_left) begin
        lf_d = 1'b0;
        rf_d = 1'b1;
      end
    end else if ((bl && br && toward_left) || (bl && !bc && !br)) begin
      tc_d       = CASE_CORNER_L;
      last_err_d = -CENTER_POSITION;
    end else if (br && (bl || !bc)) begin
      tc_d       = CASE_CORNER_R;
      last_err_d = CENTER_POSITION;
      lf_d       = 1'b0;
      rf_d       = 1'b1;
    end else if (bl) begin
      tc_d       = CASE_SLANT_L;
      last_err_d = -HALF_POSITION;
      ls_d       = SPEED_SLANT_OUT;
      rs_d       = SPEED_SLANT_IN;
      rf_d       = 1'b1;
    end else if (br) begin
      tc_d       = CASE_SLANT_R;
      last_err_d = HALF_POSITION;
      ls_d       = SPEED_SLANT_IN;
      rs_d       = SPEED_SLANT_OUT;
      rf_d       = 1'b1;
    end else if (rl_q < thl_q && rr_q < thr_q) begin
      last_err_d = '0;
      ls_d       = SPEED_STRAIGHT;
      rs_d       = SPEED_STRAIGHT;
      rf_d       = 1'b1;
    end else begin
      // a side reading sits exactly on its threshold: PD correction
      last_err_d = err;
      ls_d       = pd_clamp(sum_l, ceil_q);
      rs_d       = pd_clamp(sum_r, ceil_q);
      rf_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q  <= '0;
      last_time_q <= '0;
    end else if (advance) begin
      last_err_q <= last_err_d;
      if (!dashed) begin
        last_time_q <= now_q;
      end
    end
  end

  // result register
  logic              out_valid_q;
  logic [SpeedW-1:0] ls_q, rs_q;
  logic              lf_q, rf_q;
  track_case_e       tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ls_q <= ls_d;
      rs_q <= rs_d;
      lf_q <= lf_d;
      rf_q <= rf_d;
      tc_q <= tc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_speed_o    = ls_q;
  assign right_speed_o   = rs_q;
  assign left_forward_o  = lf_q;
  assign right_forward_o = rf_q;
  assign track_case_o    = tc_q;

endmodule

/* rtl/core/lfpd_checker.sv */
module lfpd_checker
  import lfpd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SpeedW-1:0]   left_speed_o,
  input logic                left_forward_o,
  input logic [SpeedW-1:0]   right_speed_o,
  input logic                right_forward_o,
  input logic [2:0]          track_case_o
);

  // a held result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(left_speed_o) &&
      $stable(right_speed_o) && $stable(track_case_o) &&
      $stable(left_forward_o) && $stable(right_forward_o))
    else $error("result changed while stalled");

  // input only backs up when the result stage is full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result stage");

  a_corner_l: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && track_case_o == CASE_CORNER_L |->
      left_forward_o && !right_forward_o &&
      left_speed_o == SPEED_CORNER && right_speed_o == SPEED_CORNER)
    else $error("corner left drive mismatch");

  a_slant_l: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && track_case_o == CASE_SLANT_L |->
      left_forward_o && right_forward_o &&
      left_speed_o == SPEED_SLANT_OUT && right_speed_o == SPEED_SLANT_IN)
    else $error("slant left drive mismatch");

  a_normal_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && track_case_o == CASE_NORMAL |->
      left_forward_o && right_forward_o)
    else $error("normal case not driving forward");

endmodule

bind line_follower_pd_steering lfpd_checker u_lfpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .left_speed_o    (left_speed_o),
  .left_forward_o  (left_forward_o),
  .right_speed_o   (right_speed_o),
  .right_forward_o (right_forward_o),
  .track_case_o    (track_case_o)
);

/* tb/line_follower_pd_steering_tb.sv */
`timescale 1ns / 100ps

module line_follower_pd_steering_tb
  import lfpd_pkg::*;
();

  localparam int CYCLE_LIMIT = 200_000;
  localparam int CENTER      = int'(CENTER_POSITION);

  typedef struct packed {
    logic [ThreshW-1:0] left;
    logic [ThreshW-1:0] center;
    logic [ThreshW-1:0] right;
    logic [PosW-1:0]    pos;
    logic [TimeW-1:0]   now;
  } sample_t;

  typedef struct packed {
    logic [SpeedW-1:0] l_spd;
    logic              l_fwd;
    logic [SpeedW-1:0] r_spd;
    logic              r_fwd;
    track_case_e       tcase;
  } steer_t;

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [ThreshW-1:0]  reading_left_i   = '0;
  logic [ThreshW-1:0]  reading_center_i = '0;
  logic [ThreshW-1:0]  reading_right_i  = '0;
  logic [PosW-1:0]     line_position_i  = '0;
  logic [TimeW-1:0]    now_ms_i         = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [SpeedW-1:0]   left_speed_o;
  logic                left_forward_o;
  logic [SpeedW-1:0]   right_speed_o;
  logic                right_forward_o;
  logic [2:0]          track_case_o;

  line_follower_pd_steering u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .reading_left_i  (reading_left_i),
    .reading_center_i(reading_center_i),
    .reading_right_i (reading_right_i),
    .line_position_i (line_position_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_speed_o    (left_speed_o),
    .left_forward_o  (left_forward_o),
    .right_speed_o   (right_speed_o),
    .right_forward_o (right_forward_o),
    .track_case_o    (track_case_o)
  );

  // shadow registers and steering state
  logic [ThreshW-1:0]  thr_l = RST_THRESH, thr_c = RST_THRESH, thr_r = RST_THRESH;
  logic [GainW-1:0]    kp = RST_KP, kd = RST_KD;
  logic [SpeedW-1:0]   base_spd = RST_BASE, ceil_spd = RST_CEIL;
  logic [TimeoutW-1:0] timeout_ms = RST_TIMEOUT;
  int                  last_err = 0;
  logic [TimeW-1:0]    line_time = '0;

  steer_t pending_steer_q[$];
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  int     mismatches = 0;
  int     samples_sent = 0;
  int     results_checked = 0;
  int     case_hits[6] = '{default: 0};
  int     cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_steer_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  function automatic steer_t motors(logic [SpeedW-1:0] ls, logic lf, logic [SpeedW-1:0] rs,
                                    logic rf, track_case_e tc);
    steer_t m;
    m.l_spd = ls;
    m.l_fwd = lf;
    m.r_spd = rs;
    m.r_fwd = rf;
    m.tcase = tc;
    return m;
  endfunction

  // Q8.8 to integer, truncated toward zero, negative floors at zero, capped at ceil_spd
  function automatic logic [SpeedW-1:0] clamp_speed(longint q);
    longint v;
    v = (q >= 0) ? q / 256 : 0;
    if (v > longint'(ceil_spd)) v = longint'(ceil_spd);
    return v[SpeedW-1:0];
  endfunction

  function automatic steer_t predict_steer(sample_t s);
    logic             bl, bc, br, to_left;
    logic [TimeW-1:0] elapsed;
    int               err;
    longint           corr, base;
    bl = s.left > thr_l;
    bc = s.center > thr_c;
    br = s.right > thr_r;
    to_left = (last_err <= 0);
    if (!bl && !bc && !br) begin
      elapsed = s.now - line_time;
      if (elapsed < {16'd0, timeout_ms})
        return motors(SPEED_STRAIGHT, 1'b1, SPEED_STRAIGHT, 1'b1, CASE_DASHED);
      else if (to_left)
        return motors(SPEED_CORNER, 1'b1, SPEED_CORNER, 1'b0, CASE_DASHED);
      else
        return motors(SPEED_CORNER, 1'b0, SPEED_CORNER, 1'b1, CASE_DASHED);
    end
    line_time = s.now;
    // both outer sensors dark: the last error decides the corner direction
    if (bl && (br ? to_left : !bc)) begin
      last_err = -CENTER;
      return motors(SPEED_CORNER, 1'b1, SPEED_CORNER, 1'b0, CASE_CORNER_L);
    end
    if (br && (bl || !bc)) begin
      last_err = CENTER;
      return motors(SPEED_CORNER, 1'b0, SPEED_CORNER, 1'b1, CASE_CORNER_R);
    end
    if (bl) begin
      last_err = -(CENTER / 2);
      return motors(SPEED_SLANT_OUT, 1'b1, SPEED_SLANT_IN, 1'b1, CASE_SLANT_L);
    end
    if (br) begin
      last_err = CENTER / 2;
      return motors(SPEED_SLANT_IN, 1'b1, SPEED_SLANT_OUT, 1'b1, CASE_SLANT_R);
    end
    if (s.left < thr_l && s.right < thr_r) begin
      last_err = 0;
      return motors(SPEED_STRAIGHT, 1'b1, SPEED_STRAIGHT, 1'b1, CASE_NORMAL);
    end
    // a side reading sitting exactly on its threshold falls through to PD
    err  = int'(s.pos) - CENTER;
    corr = longint'(kp) * err + longint'(kd) * (err - last_err);
    base = longint'(base_spd) * 256;
    last_err = err;
    return motors(clamp_speed(base + corr), 1'b1, clamp_speed(base - corr), 1'b1,
                  CASE_NORMAL);
  endfunction

  function automatic void check_field(string what, logic [SpeedW-1:0] want,
                                      logic [SpeedW-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : p_check
    steer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_steer_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual %0d/%0d %0d/%0d case %0d",
                 $time, left_speed_o, left_forward_o, right_speed_o, right_forward_o,
                 track_case_o);
      end else begin
        want = pending_steer_q.pop_front();
        results_checked++;
        check_field("left_speed", want.l_spd, left_speed_o);
        check_field("left_forward", SpeedW'(want.l_fwd), SpeedW'(left_forward_o));
        check_field("right_speed", want.r_spd, right_speed_o);
        check_field("right_forward", SpeedW'(want.r_fwd), SpeedW'(right_forward_o));
        check_field("track_case", SpeedW'(want.tcase), SpeedW'(track_case_o));
      end
    end
  end

  // called at a falling edge; leaves valid high for a back-to-back follower
  task automatic send_sample(input sample_t s);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i       <= 1'b1;
    reading_left_i   <= s.left;
    reading_center_i <= s.center;
    reading_right_i  <= s.right;
    line_position_i  <= s.pos;
    now_ms_i         <= s.now;
    do @(posedge clk_i); while (in_stall_o);
    pending_steer_q.push_back(predict_steer(s));
    case_hits[pending_steer_q[$].tcase]++;
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_steer_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [CfgDataW-1:0] tl, tc, tr, p, d, b, c, t);
    logic [CfgDataW-1:0] vals[8];
    cfg_reg_e            idx;
    vals = '{tl, tc, tr, p, d, b, c, t};
    drain_results();
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx)
        REG_THRESH_L: thr_l      = vals[i][ThreshW-1:0];
        REG_THRESH_C: thr_c      = vals[i][ThreshW-1:0];
        REG_THRESH_R: thr_r      = vals[i][ThreshW-1:0];
        REG_KP:       kp         = vals[i][GainW-1:0];
        REG_KD:       kd         = vals[i][GainW-1:0];
        REG_BASE:     base_spd   = vals[i][SpeedW-1:0];
        REG_CEIL:     ceil_spd   = vals[i][SpeedW-1:0];
        REG_TIMEOUT:  timeout_ms = vals[i][TimeoutW-1:0];
        default: ;
      endcase
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // dark readings above threshold (on it at 1023), light at or below; 1 in 10 random
  function automatic logic [ThreshW-1:0] pick_reading(logic [ThreshW-1:0] thr, bit dark);
    if ($urandom_range(9) == 0) return ThreshW'($urandom_range(1023));
    if (dark) return (thr == 10'd1023) ? thr : ThreshW'($urandom_range(1023, thr + 1));
    if (thr == '0 || $urandom_range(2) == 0) return thr;
    return ThreshW'($urandom_range(thr - 1, 0));
  endfunction

  function automatic sample_t random_sample();
    sample_t          s;
    logic [2:0]       dark;
    logic [TimeW-1:0] gap;
    // lean on the lost-line and center-only patterns, the stateful ones
    if ($urandom_range(3) == 0) dark = $urandom_range(1) ? 3'b000 : 3'b010;
    else dark = 3'($urandom_range(7));
    s.left   = pick_reading(thr_l, dark[2]);
    s.center = pick_reading(thr_c, dark[1]);
    s.right  = pick_reading(thr_r, dark[0]);
    case ($urandom_range(7))
      0: s.pos = '0;
      1: s.pos = 11'd2047;
      2: s.pos = 11'd1000;
      3: s.pos = PosW'($urandom_range(2047));
      default: s.pos = PosW'($urandom_range(2000));
    endcase
    case ($urandom_range(5))
      0: gap = $urandom_range(timeout_ms);
      1: gap = TimeW'(timeout_ms) - 1;
      2: gap = TimeW'(timeout_ms);
      3: gap = $urandom();
      default: gap = $urandom_range(40);
    endcase
    s.now = line_time + gap;
    return s;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(39) == 0) drain_results();
      send_sample(random_sample());
    end
    drain_results();
  endtask

  task automatic test_track_cases();
    send_sample('{10'd0, 10'd0, 10'd0, 11'd1000, 32'd0});        // lost line, just lost
    send_sample('{10'd0, 10'd0, 10'd0, 11'd1000, 32'd349});      // last ms before timeout
    send_sample('{10'd0, 10'd0, 10'd0, 11'd1000, 32'd350});      // timed out, spin left
    send_sample('{10'd0, 10'd1000, 10'd0, 11'd1000, 32'd400});   // clean center
    send_sample('{10'd1000, 10'd0, 10'd0, 11'd0, 32'd410});      // left only
    send_sample('{10'd1000, 10'd0, 10'd1000, 11'd0, 32'd420});   // both sides, error <= 0
    send_sample('{10'd0, 10'd0, 10'd1023, 11'd0, 32'd430});      // right only
    send_sample('{10'd1023, 10'd1023, 10'd1023, 11'd2047, 32'd440}); // all dark, error > 0
    send_sample('{10'd0, 10'd0, 10'd0, 11'd1000, 32'd10000});    // spin right
    send_sample('{10'd700, 10'd800, 10'd100, 11'd500, 32'd10010});
    send_sample('{10'd0, 10'd0, 10'd0, 11'd1000, 32'd20000});    // spin left after slant
    send_sample('{10'd100, 10'd800, 10'd700, 11'd1500, 32'd20010});
    send_sample('{10'd500, 10'd900, 10'd0, 11'd0, 32'd20020});   // PD, left on threshold
    send_sample('{10'd0, 10'd900, 10'd500, 11'd2047, 32'd20030}); // PD, right on threshold
    send_sample('{10'd500, 10'd900, 10'd500, 11'd1000, 32'd20040});
    send_sample('{10'd501, 10'd900, 10'd0, 11'd1000, 32'd20050}); // one above threshold
    send_sample('{10'd499, 10'd501, 10'd499, 11'd1000, 32'hFFFF_FFF0});
    send_sample('{10'd0, 10'd0, 10'd0, 11'd1000, 32'd5});        // elapsed wraps past zero
    send_sample('{10'd0, 10'd500, 10'd0, 11'd2047, 32'hFFFF_FFFF}); // center on threshold
    send_sample('{10'd1023, 10'd0, 10'd0, 11'd2047, 32'hFFFF_FFFF});
    send_sample('{10'd0, 10'd900, 10'd500, 11'd0, 32'h8000_0000});
    drain_results();
  endtask

  task automatic test_zero_settings();
    apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
    run_random(60);
  endtask

  task automatic test_full_scale_settings();
    apply_settings(16'd1000, 16'd1000, 16'd1023, 16'd4095, 16'd4095, 16'd255, 16'd255,
                   16'hFFFF);
    run_random(60);
    // high base against a low ceiling exercises the upper clamp
    apply_settings(16'd1, 16'd1, 16'd1, 16'd4095, 16'd4095, 16'd255, 16'd30, 16'd1);
    run_random(60);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 4; k++) begin
      apply_settings(CfgDataW'($urandom_range(1000)), CfgDataW'($urandom_range(1000)),
                     CfgDataW'($urandom_range(1000)), CfgDataW'($urandom_range(4095)),
                     CfgDataW'($urandom_range(4095)), CfgDataW'($urandom_range(255)),
                     CfgDataW'($urandom_range(255)), CfgDataW'($urandom_range(1000)));
      run_random(40);
    end
  endtask

  task automatic test_default_settings();
    apply_settings(CfgDataW'(RST_THRESH), CfgDataW'(RST_THRESH), CfgDataW'(RST_THRESH),
                   CfgDataW'(RST_KP), CfgDataW'(RST_KD), CfgDataW'(RST_BASE),
                   CfgDataW'(RST_CEIL), CfgDataW'(RST_TIMEOUT));
    run_random(190);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct  = 28;
    rx_stall_pct = 75;
    test_track_cases();
    test_zero_settings();

    tx_idle_pct  = 75;
    rx_stall_pct = 28;
    test_full_scale_settings();
    test_random_settings();

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    test_default_settings();

    drain_results();
    repeat (4) @(negedge clk_i);
    $display("Sent %0d samples through zero, full-scale, clamped, random and default settings",
             samples_sent);
    $display("Checked %0d results: normal %0d dashed %0d slant L/R %0d/%0d corner L/R %0d/%0d",
             results_checked, case_hits[CASE_NORMAL], case_hits[CASE_DASHED],
             case_hits[CASE_SLANT_L], case_hits[CASE_SLANT_R], case_hits[CASE_CORNER_L],
             case_hits[CASE_CORNER_R]);
    if (mismatches == 0 && pending_steer_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
